/* sv/rtp_sequence_reorder_buffer_top_defines.svh */
// Assertion macros for the RTP sequence reorder buffer.
// Used by rtp_sequence_reorder_buffer_top; expects clk and rst_n in scope.
`ifndef RTP_SEQUENCE_REORDER_BUFFER_TOP_DEFINES_SVH
`define RTP_SEQUENCE_REORDER_BUFFER_TOP_DEFINES_SVH

// same-cycle implication
`define RSRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rsrb_pkg.sv */
// Shared constants and types for the RTP sequence reorder buffer.
// No dependencies; used by rsrb_cell and rtp_sequence_reorder_buffer_top.
`timescale 1ns / 1ps
`default_nettype none

package rsrb_pkg;

  localparam int SEQ_W      = 32;
  localparam int THR_W      = 4;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_REORDER_ENABLE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_THRESHOLD = 1'd1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic step;
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/rsrb_cell.sv */
// One slot of the sorted store: holds a sequence number and tag, compares
// against the arriving word, and shifts toward its neighbors. Uses rsrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsrb_cell #(
  parameter int TAG_BITS = 8
) (
  input  wire                              clk,
  input  wire rsrb_pkg::cell_ctrl_t        ctrl,
  input  wire                              occ,
  input  wire [rsrb_pkg::SEQ_W-1:0]        new_seq,
  input  wire [TAG_BITS-1:0]               new_tag,
  input  wire                              left_lt,
  input  wire [rsrb_pkg::SEQ_W-1:0]        left_seq,
  input  wire [TAG_BITS-1:0]               left_tag,
  input  wire [rsrb_pkg::SEQ_W-1:0]        right_l1_seq,
  input  wire [TAG_BITS-1:0]               right_l1_tag,
  output logic                             lt,
  output logic                             eq,
  output logic [rsrb_pkg::SEQ_W-1:0]       seq,
  output logic [TAG_BITS-1:0]              tag,
  output logic [rsrb_pkg::SEQ_W-1:0]       l1_seq,
  output logic [TAG_BITS-1:0]              l1_tag
);

  logic [rsrb_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [TAG_BITS-1:0]        tag_r, tag_nxt;

  assign seq = seq_r;
  assign tag = tag_r;
  assign lt  = occ && (seq_r < new_seq);
  assign eq  = occ && (seq_r == new_seq);

  // contents after the insert, before the front pop
  always_comb begin
    l1_seq = seq_r;
    l1_tag = tag_r;
    if (ctrl.ins && !lt) begin
      if (left_lt) begin
        l1_seq = new_seq;
        l1_tag = new_tag;
      end else begin
        l1_seq = left_seq;
        l1_tag = left_tag;
      end
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    tag_nxt = tag_r;
    if (ctrl.step) begin
      if (ctrl.pop) begin
        seq_nxt = right_l1_seq;
        tag_nxt = right_l1_tag;
      end else begin
        seq_nxt = l1_seq;
        tag_nxt = l1_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    tag_r <= tag_nxt;
  end

endmodule

`default_nettype wire

/* sv/rtp_sequence_reorder_buffer_top.sv */
// RTP sequence reorder buffer: usage
//   in_*  : one word per packet or poll (in_has_packet=0), valid/ready.
//   out_* : released packets in ascending sequence order, valid/ready.
//   cfg_* : register writes, index 0 = reorder_enable, 1 = hold_threshold;
//           always ready, write only while the block is idle.
// Each accepted word is fully processed in the cycle it is taken: the chain
// of cells compares it against every held entry in parallel, inserts it in
// place (duplicates and arrivals to a full store are dropped) and, when the
// count exceeds hold_threshold, shifts the lowest entry out.
// Results are registered: a result appears on out_* in the cycle after its input is accepted.
// Throughput: one word per cycle while out_ready is high; the single output
// register is the only buffering, so in_ready falls while a result waits.
// Bypass (reorder_enable=0 or hold_threshold=0): packets pass through,
// polls give nothing, held entries stay put.
// Reset: count, out_valid and the config registers clear at once; no clearing pass is needed.
// Stall: a held result stays on out_* until taken; no input is accepted.
// Files: rsrb_pkg, rsrb_cell, rtp_sequence_reorder_buffer_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rtp_sequence_reorder_buffer_top_defines.svh"

module rtp_sequence_reorder_buffer_top #(
  parameter int BUFFER_DEPTH = 16,
  parameter int TAG_BITS     = 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_has_packet,
  input  wire [rsrb_pkg::SEQ_W-1:0]          in_seq_number,
  input  wire [TAG_BITS-1:0]                 in_packet_tag,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [rsrb_pkg::SEQ_W-1:0]         out_seq,
  output logic [TAG_BITS-1:0]                out_tag,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [rsrb_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  wire [rsrb_pkg::SEQ_W-1:0]          cfg_data
);

  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int CMPW = (CW > rsrb_pkg::THR_W) ? CW : rsrb_pkg::THR_W;

  logic                        reorder_enable_r, reorder_enable_nxt;
  logic [rsrb_pkg::THR_W-1:0]  hold_threshold_r, hold_threshold_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [rsrb_pkg::SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic [TAG_BITS-1:0]         out_tag_r, out_tag_nxt;

  logic                 in_fire, bypass, byp_fire, dup, full;
  logic [CW-1:0]        count_ins;
  rsrb_pkg::cell_ctrl_t ctrl;

  logic [BUFFER_DEPTH-1:0]    occ, lt, eq;
  logic [rsrb_pkg::SEQ_W-1:0] seq_q  [BUFFER_DEPTH];
  logic [TAG_BITS-1:0]        tag_q  [BUFFER_DEPTH];
  logic [rsrb_pkg::SEQ_W-1:0] l1_seq [BUFFER_DEPTH];
  logic [TAG_BITS-1:0]        l1_tag [BUFFER_DEPTH];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_seq   = out_seq_r;
  assign out_tag   = out_tag_r;

  assign bypass    = !reorder_enable_r || (hold_threshold_r == '0);
  assign byp_fire  = in_fire && bypass && in_has_packet;
  assign dup       = |eq;
  assign full      = (count_r == CW'(BUFFER_DEPTH));
  assign ctrl.step = in_fire && !bypass;
  assign ctrl.ins  = ctrl.step && in_has_packet && !dup && !full;
  assign count_ins = count_r + CW'(ctrl.ins);
  assign ctrl.pop  = ctrl.step && (CMPW'(count_ins) > CMPW'(hold_threshold_r));

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    logic                       left_lt;
    logic [rsrb_pkg::SEQ_W-1:0] left_seq, right_seq;
    logic [TAG_BITS-1:0]        left_tag, right_tag;

    assign occ[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_seq = in_seq_number;
      assign left_tag = in_packet_tag;
    end else begin : g_mid
      assign left_lt  = lt[i-1];
      assign left_seq = seq_q[i-1];
      assign left_tag = tag_q[i-1];
    end

    if (i == BUFFER_DEPTH - 1) begin : g_last
      assign right_seq = seq_q[i];
      assign right_tag = tag_q[i];
    end else begin : g_inner
      assign right_seq = l1_seq[i+1];
      assign right_tag = l1_tag[i+1];
    end

    rsrb_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occ          (occ[i]),
      .new_seq      (in_seq_number),
      .new_tag      (in_packet_tag),
      .left_lt      (left_lt),
      .left_seq     (left_seq),
      .left_tag     (left_tag),
      .right_l1_seq (right_seq),
      .right_l1_tag (right_tag),
      .lt           (lt[i]),
      .eq           (eq[i]),
      .seq          (seq_q[i]),
      .tag          (tag_q[i]),
      .l1_seq       (l1_seq[i]),
      .l1_tag       (l1_tag[i])
    );
  end

  always_comb begin
    reorder_enable_nxt = reorder_enable_r;
    hold_threshold_nxt = hold_threshold_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsrb_pkg::CFG_REORDER_ENABLE: reorder_enable_nxt = cfg_data[0];
        rsrb_pkg::CFG_HOLD_THRESHOLD: hold_threshold_nxt = cfg_data[rsrb_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.step) begin
      count_nxt = count_ins - CW'(ctrl.pop);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_seq_nxt   = out_seq_r;
    out_tag_nxt   = out_tag_r;
    if (byp_fire) begin
      out_valid_nxt = 1'b1;
      out_seq_nxt   = in_seq_number;
      out_tag_nxt   = in_packet_tag;
    end else if (ctrl.pop) begin
      out_valid_nxt = 1'b1;
      out_seq_nxt   = l1_seq[0];
      out_tag_nxt   = l1_tag[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reorder_enable_r <= 1'b0;
      hold_threshold_r <= '0;
      count_r          <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      reorder_enable_r <= reorder_enable_nxt;
      hold_threshold_r <= hold_threshold_nxt;
      count_r          <= count_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_seq_r <= out_seq_nxt;
    out_tag_r <= out_tag_nxt;
  end

  `RSRB_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(BUFFER_DEPTH), "count exceeds depth")
  `RSRB_ASSERT_NEXT(a_idle_count, ctrl.step && !ctrl.ins && !ctrl.pop, $stable(count_r), "count moved")
  `RSRB_ASSERT_NEXT(a_bypass, byp_fire, out_valid_r && out_seq_r == $past(in_seq_number), "bypass")

endmodule

`default_nettype wire
